/* design/atcli_pkg.sv */
// Shared constants, codes and types of the AT command line interpreter.
package atcli_pkg;

	localparam int LINE_DEPTH = 256;
	localparam int ADDR_W = $clog2(LINE_DEPTH);
	localparam int CNT_W = ADDR_W + 1;
	localparam int HEAD_N = 8;

	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_EQ = 8'h3D;
	localparam logic [7:0] CH_QM = 8'h3F;
	localparam logic [7:0] CH_ZERO = 8'h30;

	localparam logic [6:0] TERM_RST = 7'd13;
	localparam logic [6:0] LF_RST = 7'd10;
	localparam logic [6:0] BS_RST = 7'd8;

	localparam logic [1:0] PH_WAIT_A = 2'd0;
	localparam logic [1:0] PH_A_SEEN = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_ERROR = 2'd1;
	localparam logic [1:0] ST_CONNECT = 2'd2;

	localparam logic [4:0] CMD_UNKNOWN = 5'd0;
	localparam logic [4:0] CMD_EMPTY = 5'd1;
	localparam logic [4:0] CMD_E0 = 5'd2;
	localparam logic [4:0] CMD_E1 = 5'd3;
	localparam logic [4:0] CMD_Q0 = 5'd4;
	localparam logic [4:0] CMD_Q1 = 5'd5;
	localparam logic [4:0] CMD_S3 = 5'd6;
	localparam logic [4:0] CMD_S4 = 5'd7;
	localparam logic [4:0] CMD_S5 = 5'd8;
	localparam logic [4:0] CMD_V0 = 5'd9;
	localparam logic [4:0] CMD_V1 = 5'd10;
	localparam logic [4:0] CMD_Z = 5'd11;
	localparam logic [4:0] CMD_F0 = 5'd12;
	localparam logic [4:0] CMD_GMI = 5'd13;
	localparam logic [4:0] CMD_GMM = 5'd14;
	localparam logic [4:0] CMD_GMR = 5'd15;
	localparam logic [4:0] CMD_CGMI = 5'd16;
	localparam logic [4:0] CMD_CGMM = 5'd17;
	localparam logic [4:0] CMD_CGMR = 5'd18;
	localparam logic [4:0] CMD_CPROT = 5'd19;

	typedef struct packed {
		logic [6:0] term;
		logic [6:0] lf;
		logic [6:0] bs;
		logic       echo;
		logic       quiet;
		logic       verbose;
	} cfg_regs_t;

	typedef struct packed {
		logic [4:0] id;
		logic [1:0] status;
		logic       qv;
		logic [6:0] qval;
		cfg_regs_t  regs;
	} match_res_t;

endpackage

/* design/at_command_line_interpreter.sv */
// Top level of the AT command line interpreter: prefix, line store and line scan.
// A byte that does not end a line gives its result in the cycle after the transfer.
// A byte that ends a line scans the stored line, each character read in S_RD and
// checked in S_CK, up to the first zero byte or line end, then matched in S_FIN.
// One byte is in work at a time; the line store memory port sets the scan rate.
// Reset restores the default S registers and flags; the line store is not cleared.
module at_command_line_interpreter
	import atcli_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       echo_valid,
	output logic [7:0] echo_byte,
	output logic       line_done,
	output logic [4:0] command_id,
	output logic [1:0] status,
	output logic       query_valid,
	output logic [6:0] query_value,
	output logic       quiet_flag,
	output logic       verbose_flag,
	output logic [6:0] line_end_char,
	output logic [6:0] line_feed_char
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_RD   = 4'b0010,
		S_CK   = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                  state_q;
	logic [1:0]              phase_q;
	logic [CNT_W-1:0]        len_q;
	logic [CNT_W-1:0]        idx_q;
	cfg_regs_t               regs_q;
	logic [HEAD_N-1:0][7:0]  chr_q;
	logic                    digit_q;
	logic [10:0]             num_q;
	logic [7:0]              byte_q;
	logic [7:0]              mem [LINE_DEPTH];
	logic [7:0]              rdata_q;
	logic                    mem_we;
	logic                    out_valid_q;
	match_res_t              res;
	logic                    in_fire;
	logic                    is_term;
	logic                    is_bs;
	logic                    rd_digit;

	assign in_ready = state_q == S_IDLE && !out_valid_q;
	assign in_fire = in_valid && in_ready;
	assign is_term = rx_byte == {1'b0, regs_q.term};
	assign is_bs = rx_byte == {1'b0, regs_q.bs};
	assign mem_we = in_fire && phase_q == PH_COLLECT && !is_term && !is_bs
		&& len_q + CNT_W'(1) < CNT_W'(LINE_DEPTH);
	assign rd_digit = rdata_q >= 8'h30 && rdata_q <= 8'h39;

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[len_q[ADDR_W-1:0]] <= rx_byte;
		rdata_q <= mem[idx_q[ADDR_W-1:0]];
	end

	atcli_match u_match (
		.chr       (chr_q),
		.n         (idx_q),
		.all_digit (digit_q),
		.num       (num_q),
		.cur       (regs_q),
		.res       (res)
	);

	assign out_valid = out_valid_q;
	assign quiet_flag = regs_q.quiet;
	assign verbose_flag = regs_q.verbose;
	assign line_end_char = regs_q.term;
	assign line_feed_char = regs_q.lf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_WAIT_A;
			len_q <= '0;
			idx_q <= '0;
			regs_q <= '{term: TERM_RST, lf: LF_RST, bs: BS_RST,
				echo: 1'b1, quiet: 1'b0, verbose: 1'b1};
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						byte_q <= rx_byte;
						echo_byte <= rx_byte;
						line_done <= 1'b0;
						command_id <= CMD_UNKNOWN;
						status <= ST_OK;
						query_valid <= 1'b0;
						query_value <= '0;
						echo_valid <= regs_q.echo;
						idx_q <= '0;
						digit_q <= 1'b1;
						num_q <= '0;
						out_valid_q <= 1'b1;
						if (phase_q == PH_WAIT_A) begin
							if (rx_byte == CH_A)
								phase_q <= PH_A_SEEN;
							else
								echo_valid <= 1'b0;
						end else if (phase_q == PH_A_SEEN) begin
							if (rx_byte == CH_T) begin
								phase_q <= PH_COLLECT;
								len_q <= '0;
							end else if (rx_byte == CH_SLASH) begin
								out_valid_q <= 1'b0;
								state_q <= S_RD;
							end else begin
								phase_q <= PH_WAIT_A;
							end
						end else begin
							if (is_term) begin
								out_valid_q <= 1'b0;
								state_q <= S_RD;
							end else if (is_bs) begin
								if (len_q != '0)
									len_q <= len_q - CNT_W'(1);
								else
									phase_q <= PH_A_SEEN;
							end else if (mem_we) begin
								len_q <= len_q + CNT_W'(1);
							end else begin
								echo_valid <= 1'b0;
							end
						end
					end
				end
				S_RD: begin
					if (idx_q == len_q)
						state_q <= S_FIN;
					else
						state_q <= S_CK;
				end
				S_CK: begin
					if (rdata_q == 8'h00) begin
						state_q <= S_FIN;
					end else begin
						if (idx_q < CNT_W'(HEAD_N))
							chr_q[idx_q[2:0]] <= rdata_q;
						if (idx_q >= CNT_W'(3)) begin
							digit_q <= digit_q && rd_digit;
							if (num_q <= 11'd127)
								num_q <= (num_q << 3) + (num_q << 1)
									+ {3'b000, rdata_q - 8'h30};
						end
						idx_q <= idx_q + CNT_W'(1);
						state_q <= S_RD;
					end
				end
				S_FIN: begin
					regs_q <= res.regs;
					phase_q <= PH_WAIT_A;
					line_done <= 1'b1;
					command_id <= res.id;
					status <= res.status;
					query_valid <= res.qv;
					query_value <= res.qval;
					echo_valid <= res.regs.echo;
					echo_byte <= byte_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q)) else $error("scan state not one-hot");
	a_busy_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> !out_valid_q) else $error("result pending during scan");
	a_plain_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !line_done |-> command_id == CMD_UNKNOWN && status == ST_OK
		&& !query_valid) else $error("command fields set without a line");
	a_fin_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |=> out_valid_q && line_done) else $error("line result lost");

endmodule

/* design/atcli_match.sv */
// Command table match and execution of one scanned command line.
module atcli_match
	import atcli_pkg::*;
(
	input  logic [HEAD_N-1:0][7:0] chr,
	input  logic [CNT_W-1:0]       n,
	input  logic                   all_digit,
	input  logic [10:0]            num,
	input  cfg_regs_t              cur,
	output match_res_t             res
);

	function automatic logic eqf(input logic [7:0] c, input logic [7:0] t);
		logic [7:0] f;
		f = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
		return f == t;
	endfunction

	function automatic logic sep(input logic [7:0] c);
		return c == CH_EQ || c == CH_QM;
	endfunction

	logic [4:0] id;
	logic       t1, t2, t3, t4, t5, t6;
	logic       s_set, s_qry;

	always_comb begin
		t1 = n == CNT_W'(1) || sep(chr[1]);
		t2 = n == CNT_W'(2) || sep(chr[2]);
		t3 = n == CNT_W'(3) || sep(chr[3]);
		t4 = n == CNT_W'(4) || sep(chr[4]);
		t5 = n == CNT_W'(5) || sep(chr[5]);
		t6 = n == CNT_W'(6) || sep(chr[6]);
		id = CMD_UNKNOWN;
		if (n == '0 || sep(chr[0]))
			id = CMD_EMPTY;
		else if (n >= CNT_W'(2) && eqf(chr[0], "E") && eqf(chr[1], "0") && t2)
			id = CMD_E0;
		else if (n >= CNT_W'(2) && eqf(chr[0], "E") && eqf(chr[1], "1") && t2)
			id = CMD_E1;
		else if (n >= CNT_W'(2) && eqf(chr[0], "Q") && eqf(chr[1], "0") && t2)
			id = CMD_Q0;
		else if (n >= CNT_W'(2) && eqf(chr[0], "Q") && eqf(chr[1], "1") && t2)
			id = CMD_Q1;
		else if (n >= CNT_W'(2) && eqf(chr[0], "S") && eqf(chr[1], "3") && t2)
			id = CMD_S3;
		else if (n >= CNT_W'(2) && eqf(chr[0], "S") && eqf(chr[1], "4") && t2)
			id = CMD_S4;
		else if (n >= CNT_W'(2) && eqf(chr[0], "S") && eqf(chr[1], "5") && t2)
			id = CMD_S5;
		else if (n >= CNT_W'(2) && eqf(chr[0], "V") && eqf(chr[1], "0") && t2)
			id = CMD_V0;
		else if (n >= CNT_W'(2) && eqf(chr[0], "V") && eqf(chr[1], "1") && t2)
			id = CMD_V1;
		else if (n >= CNT_W'(1) && eqf(chr[0], "Z") && t1)
			id = CMD_Z;
		else if (n >= CNT_W'(3) && eqf(chr[0], "&") && eqf(chr[1], "F")
				&& eqf(chr[2], "0") && t3)
			id = CMD_F0;
		else if (n >= CNT_W'(4) && eqf(chr[0], "+") && eqf(chr[1], "G")
				&& eqf(chr[2], "M") && eqf(chr[3], "I") && t4)
			id = CMD_GMI;
		else if (n >= CNT_W'(4) && eqf(chr[0], "+") && eqf(chr[1], "G")
				&& eqf(chr[2], "M") && eqf(chr[3], "M") && t4)
			id = CMD_GMM;
		else if (n >= CNT_W'(4) && eqf(chr[0], "+") && eqf(chr[1], "G")
				&& eqf(chr[2], "M") && eqf(chr[3], "R") && t4)
			id = CMD_GMR;
		else if (n >= CNT_W'(5) && eqf(chr[0], "+") && eqf(chr[1], "C") && eqf(chr[2], "G")
				&& eqf(chr[3], "M") && eqf(chr[4], "I") && t5)
			id = CMD_CGMI;
		else if (n >= CNT_W'(5) && eqf(chr[0], "+") && eqf(chr[1], "C") && eqf(chr[2], "G")
				&& eqf(chr[3], "M") && eqf(chr[4], "M") && t5)
			id = CMD_CGMM;
		else if (n >= CNT_W'(5) && eqf(chr[0], "+") && eqf(chr[1], "C") && eqf(chr[2], "G")
				&& eqf(chr[3], "M") && eqf(chr[4], "R") && t5)
			id = CMD_CGMR;
		else if (n >= CNT_W'(6) && eqf(chr[0], "+") && eqf(chr[1], "C") && eqf(chr[2], "P")
				&& eqf(chr[3], "R") && eqf(chr[4], "O") && eqf(chr[5], "T") && t6)
			id = CMD_CPROT;

		s_qry = n >= CNT_W'(3) && chr[2] == CH_QM;
		s_set = n >= CNT_W'(4) && chr[2] == CH_EQ && all_digit && num <= 11'd127;

		res.id = id;
		res.status = ST_OK;
		res.qv = 1'b0;
		res.qval = '0;
		res.regs = cur;
		case (id)
			CMD_UNKNOWN: res.status = ST_ERROR;
			CMD_E0: res.regs.echo = 1'b0;
			CMD_E1: res.regs.echo = 1'b1;
			CMD_Q0: res.regs.quiet = 1'b0;
			CMD_Q1: res.regs.quiet = 1'b1;
			CMD_V0: res.regs.verbose = 1'b0;
			CMD_V1: res.regs.verbose = 1'b1;
			CMD_S3, CMD_S4, CMD_S5: begin
				if (s_qry) begin
					res.qv = 1'b1;
					res.qval = (id == CMD_S3) ? cur.term : (id == CMD_S4) ? cur.lf : cur.bs;
				end else if (s_set) begin
					if (id == CMD_S3)
						res.regs.term = num[6:0];
					else if (id == CMD_S4)
						res.regs.lf = num[6:0];
					else
						res.regs.bs = num[6:0];
				end else begin
					res.status = ST_ERROR;
				end
			end
			CMD_Z, CMD_F0: begin
				res.regs.term = TERM_RST;
				res.regs.lf = LF_RST;
				res.regs.bs = BS_RST;
				res.regs.echo = 1'b1;
				res.regs.quiet = 1'b0;
				res.regs.verbose = 1'b1;
			end
			CMD_GMI, CMD_GMM, CMD_GMR: begin
				if (n == CNT_W'(4))
					res.qv = 1'b1;
				else
					res.status = ST_ERROR;
			end
			CMD_CGMI, CMD_CGMM, CMD_CGMR: begin
				if (n == CNT_W'(5))
					res.qv = 1'b1;
				else
					res.status = ST_ERROR;
			end
			CMD_CPROT: begin
				if (n == CNT_W'(8) && chr[6] == CH_EQ && chr[7] == CH_QM)
					res.qv = 1'b1;
				else if (n == CNT_W'(8) && chr[6] == CH_EQ && chr[7] == CH_ZERO)
					res.status = ST_CONNECT;
				else
					res.status = ST_ERROR;
			end
			default: ;
		endcase
	end

endmodule

/* test/tb_at_command_line_interpreter.sv */
// Self-checking testbench of the AT command line interpreter.
typedef struct {
	logic       echo_valid;
	logic [7:0] echo_byte;
	logic       line_done;
	logic [4:0] command_id;
	logic [1:0] status;
	logic       query_valid;
	logic [6:0] query_value;
	logic       quiet_flag;
	logic       verbose_flag;
	logic [6:0] line_end_char;
	logic [6:0] line_feed_char;
} reply_t;

class atcli_scoreboard;
	reply_t pending[$];
	bit failed;
	logic [1:0] phase;
	logic [7:0] store [atcli_pkg::LINE_DEPTH];
	int unsigned len;
	logic [6:0] term, lf, bs;
	logic echo, quiet, verbose;
	string names[19] = '{"", "E0", "E1", "Q0", "Q1", "S3", "S4", "S5", "V0", "V1", "Z",
		"&F0", "+GMI", "+GMM", "+GMR", "+CGMI", "+CGMM", "+CGMR", "+CPROT"};

	function void restore_defaults();
		term = atcli_pkg::TERM_RST;
		lf = atcli_pkg::LF_RST;
		bs = atcli_pkg::BS_RST;
		echo = 1'b1;
		quiet = 1'b0;
		verbose = 1'b1;
	endfunction

	function void clear();
		phase = atcli_pkg::PH_WAIT_A;
		len = 0;
		foreach (store[i]) store[i] = 8'd0;
		restore_defaults();
	endfunction

	function logic [7:0] upper(logic [7:0] c);
		return (c >= "a" && c <= "z") ? c - 8'd32 : c;
	endfunction

	function logic [1:0] s_register(inout logic [6:0] reg_val, input int unsigned first,
		input int unsigned n, output logic qv, output logic [6:0] qval);
		int unsigned v;
		v = 0;
		qv = 1'b0;
		qval = '0;
		if (n > first && store[first] == atcli_pkg::CH_QM) begin
			qv = 1'b1;
			qval = reg_val;
			return atcli_pkg::ST_OK;
		end
		if (n >= first + 2 && store[first] == atcli_pkg::CH_EQ) begin
			for (int unsigned i = first + 1; i < n; i++) begin
				if (store[i] < "0" || store[i] > "9")
					return atcli_pkg::ST_ERROR;
				if (v <= 127)
					v = v * 10 + (store[i] - "0");
			end
			if (v > 127)
				return atcli_pkg::ST_ERROR;
			reg_val = v[6:0];
			return atcli_pkg::ST_OK;
		end
		return atcli_pkg::ST_ERROR;
	endfunction

	function void execute_line(ref reply_t r);
		int unsigned n, nl;
		int found;
		bit same;
		n = 0;
		found = -1;
		nl = 0;
		while (n < len && store[n] != 8'd0)
			n++;
		for (int e = 0; e < 19 && found < 0; e++) begin
			nl = names[e].len();
			if (nl > n)
				continue;
			same = 1;
			for (int k = 0; k < nl; k++)
				if (upper(store[k]) != names[e][k])
					same = 0;
			if (same && (nl == n || store[nl] == atcli_pkg::CH_EQ ||
					store[nl] == atcli_pkg::CH_QM))
				found = e;
		end
		r.line_done = 1'b1;
		if (found < 0) begin
			r.command_id = atcli_pkg::CMD_UNKNOWN;
			r.status = atcli_pkg::ST_ERROR;
			return;
		end
		nl = names[found].len();
		r.command_id = atcli_pkg::CMD_EMPTY + found;
		r.status = atcli_pkg::ST_OK;
		case (r.command_id)
			atcli_pkg::CMD_E0: echo = 1'b0;
			atcli_pkg::CMD_E1: echo = 1'b1;
			atcli_pkg::CMD_Q0: quiet = 1'b0;
			atcli_pkg::CMD_Q1: quiet = 1'b1;
			atcli_pkg::CMD_S3: r.status = s_register(term, nl, n, r.query_valid, r.query_value);
			atcli_pkg::CMD_S4: r.status = s_register(lf, nl, n, r.query_valid, r.query_value);
			atcli_pkg::CMD_S5: r.status = s_register(bs, nl, n, r.query_valid, r.query_value);
			atcli_pkg::CMD_V0: verbose = 1'b0;
			atcli_pkg::CMD_V1: verbose = 1'b1;
			atcli_pkg::CMD_Z, atcli_pkg::CMD_F0: restore_defaults();
			atcli_pkg::CMD_GMI, atcli_pkg::CMD_GMM, atcli_pkg::CMD_GMR,
			atcli_pkg::CMD_CGMI, atcli_pkg::CMD_CGMM, atcli_pkg::CMD_CGMR: begin
				if (n == nl)
					r.query_valid = 1'b1;
				else
					r.status = atcli_pkg::ST_ERROR;
			end
			atcli_pkg::CMD_CPROT: begin
				if (n == nl + 2 && store[nl] == atcli_pkg::CH_EQ && store[nl + 1] == atcli_pkg::CH_QM)
					r.query_valid = 1'b1;
				else if (n == nl + 2 && store[nl] == atcli_pkg::CH_EQ &&
						store[nl + 1] == atcli_pkg::CH_ZERO)
					r.status = atcli_pkg::ST_CONNECT;
				else
					r.status = atcli_pkg::ST_ERROR;
			end
			default: ;
		endcase
	endfunction

	function void note_byte(logic [7:0] b);
		reply_t r;
		bit taken;
		r = '{default: '0};
		taken = 1;
		r.echo_byte = b;
		if (phase == atcli_pkg::PH_WAIT_A) begin
			if (b == atcli_pkg::CH_A)
				phase = atcli_pkg::PH_A_SEEN;
			else
				taken = 0;
		end else if (phase == atcli_pkg::PH_A_SEEN) begin
			if (b == atcli_pkg::CH_T) begin
				phase = atcli_pkg::PH_COLLECT;
				len = 0;
			end else if (b == atcli_pkg::CH_SLASH) begin
				execute_line(r);
				phase = atcli_pkg::PH_WAIT_A;
			end else begin
				phase = atcli_pkg::PH_WAIT_A;
			end
		end else begin
			if (b == {1'b0, term}) begin
				execute_line(r);
				phase = atcli_pkg::PH_WAIT_A;
			end else if (b == {1'b0, bs}) begin
				if (len > 0)
					len--;
				else
					phase = atcli_pkg::PH_A_SEEN;
			end else if (len + 1 < atcli_pkg::LINE_DEPTH) begin
				store[len] = b;
				len++;
			end else begin
				taken = 0;
			end
		end
		r.echo_valid = taken && echo;
		r.quiet_flag = quiet;
		r.verbose_flag = verbose;
		r.line_end_char = term;
		r.line_feed_char = lf;
		pending.push_back(r);
	endfunction

	function void compare(string field, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", field, exp_v, act_v);
			failed = 1;
		end
	endfunction

	function void check_reply(reply_t a);
		reply_t e;
		if (pending.size() == 0) begin
			$error("result transfer with no expected result");
			failed = 1;
			return;
		end
		e = pending.pop_front();
		compare("echo_valid", e.echo_valid, a.echo_valid);
		compare("echo_byte", e.echo_byte, a.echo_byte);
		compare("line_done", e.line_done, a.line_done);
		compare("command_id", e.command_id, a.command_id);
		compare("status", e.status, a.status);
		compare("query_valid", e.query_valid, a.query_valid);
		compare("query_value", e.query_value, a.query_value);
		compare("quiet_flag", e.quiet_flag, a.quiet_flag);
		compare("verbose_flag", e.verbose_flag, a.verbose_flag);
		compare("line_end_char", e.line_end_char, a.line_end_char);
		compare("line_feed_char", e.line_feed_char, a.line_feed_char);
	endfunction
endclass

module tb_at_command_line_interpreter;
	import atcli_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic       echo_valid;
	logic [7:0] echo_byte;
	logic       line_done;
	logic [4:0] command_id;
	logic [1:0] status;
	logic       query_valid;
	logic [6:0] query_value;
	logic       quiet_flag;
	logic       verbose_flag;
	logic [6:0] line_end_char;
	logic [6:0] line_feed_char;

	atcli_scoreboard sb;
	bit idle_on = 1;
	bit drained = 0;
	int bytes_sent = 0;
	string cmds[22] = '{"", "E0", "E1", "Q0", "Q1", "S3", "S4", "S5", "V0", "V1", "Z",
		"&F0", "+GMI", "+GMM", "+GMR", "+CGMI", "+CGMM", "+CGMR", "+CPROT", "X", "GMI", "S9"};

	at_command_line_interpreter u_dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

	task automatic send_byte(logic [7:0] b);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 26) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i]);
	endtask

	task automatic send_line(string s);
		send_text({"AT", s});
		send_byte({1'b0, sb.term});
	endtask

	function automatic string random_case(string s);
		string t;
		t = s;
		for (int i = 0; i < t.len(); i++)
			if (t[i] >= "A" && t[i] <= "Z" && $urandom_range(1))
				t[i] = t[i] + 8'd32;
		return t;
	endfunction

	function automatic string random_arg(int c);
		case ($urandom_range(9))
			0: return "?";
			1: return "=?";
			2: return "=0";
			3: return "=";
			4: return $sformatf("=%0d", $urandom_range(200));
			5: return (c == 5) ? "=13" : ((c == 7) ? "=8" : $sformatf("=%0d", $urandom_range(127)));
			6: return (c == 5) ? "=13" : ((c == 7) ? "=8" : "=10");
			7: return $sformatf("=%0da", $urandom_range(9));
			8: return $sformatf("%c%c", $urandom_range(32, 126), $urandom_range(32, 126));
			default: return "";
		endcase
	endfunction

	task automatic random_sequence();
		int c;
		string s;
		case ($urandom_range(19))
			0: send_byte($urandom_range(255));
			1: send_text({"A", string'(8'($urandom_range(255)))});
			2: send_text("A/");
			3: send_line("&F0");
			4: begin
				send_text("AT");
				send_byte({1'b0, sb.bs});
				send_byte($urandom_range(1) ? CH_T : CH_SLASH);
			end
			default: begin
				c = $urandom_range(21);
				s = {random_case(cmds[c]), random_arg(c)};
				send_text("AT");
				for (int i = 0; i < s.len(); i++) begin
					if ($urandom_range(29) == 0) begin
						send_byte($urandom_range(32, 126));
						send_byte({1'b0, sb.bs});
					end
					send_byte(s[i]);
				end
				send_byte({1'b0, sb.term});
			end
		endcase
	endtask

	initial begin
		reply_t got;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.echo_valid = echo_valid;
				got.echo_byte = echo_byte;
				got.line_done = line_done;
				got.command_id = command_id;
				got.status = status;
				got.query_valid = query_valid;
				got.query_value = query_value;
				got.quiet_flag = quiet_flag;
				got.verbose_flag = verbose_flag;
				got.line_end_char = line_end_char;
				got.line_feed_char = line_feed_char;
				sb.check_reply(got);
			end
			@(negedge clk);
			out_ready <= !(idle_on && $urandom_range(99) < 26);
		end
	end

	initial begin
		string longline;
		sb = new();
		sb.clear();
		in_valid = 1'b0;
		rx_byte = 8'd0;
		out_ready = 1'b0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_text("A/");
		send_byte(8'hFF);
		send_text("AX");
		send_line("");
		send_line("?");
		for (int c = 1; c < 19; c++)
			send_line(random_case(cmds[c]));
		send_line("s3?");
		send_line("S4=127");
		send_line("S4=128");
		send_line("S5=");
		send_line("+CPROT=?");
		send_line("+cprot=0");
		send_line("+CPROT=00");
		send_line("+GMI=1");
		send_line("E1\0xyz");
		send_line("S5=13");
		send_line("Q1");
		send_text("A/");
		send_line("&F0");
		send_text("AT");
		send_byte(8'd8);
		send_text("T");
		send_byte(8'd8);
		send_text("Z");
		send_byte(8'd13);
		longline = "";
		for (int i = 0; i < 270; i++)
			longline = {longline, "x"};
		send_line(longline);
		send_text("A/");
		send_line("V0");

		while (bytes_sent < 1750) begin
			idle_on = !(bytes_sent > 600 && bytes_sent < 900);
			if (!drained && bytes_sent > 1100) begin
				drained = 1'b1;
				@(negedge clk);
				in_valid <= 1'b0;
				while (sb.pending.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(99) == 0) begin
				longline = "";
				for (int i = 0; i < $urandom_range(240, 260); i++)
					longline = {longline, string'(8'($urandom_range(1, 127)))};
				send_text({"AT", longline});
			end else
				random_sequence();
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (!sb.failed && sb.pending.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
